// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker in bmp24_chk.sv.
// No dependencies; every macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define BMP24_AST_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// ante at an edge implies cons at the same edge
`define BMP24_AST_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante at an edge implies cons at the next edge
`define BMP24_AST_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/bmp24_pkg.sv =====
// Shared types and constants for the 24-bit bitmap stream decoder.
// No dependencies.
package bmp24_pkg;

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_ERR_SIG = 2'd2;
	localparam logic [1:0] KIND_ERR_BPP = 2'd3;

	localparam logic [15:0] BMP_MAGIC = 16'h4D42;
	localparam logic [15:0] BMP_BITS  = 16'd24;

	localparam logic [5:0] POS_SIG_HI  = 6'd1;
	localparam logic [5:0] POS_SIG_LO  = 6'd0;
	localparam logic [5:0] POS_W0      = 6'd18;
	localparam logic [5:0] POS_W1      = 6'd19;
	localparam logic [5:0] POS_W2      = 6'd20;
	localparam logic [5:0] POS_W3      = 6'd21;
	localparam logic [5:0] POS_H0      = 6'd22;
	localparam logic [5:0] POS_H1      = 6'd23;
	localparam logic [5:0] POS_H2      = 6'd24;
	localparam logic [5:0] POS_H3      = 6'd25;
	localparam logic [5:0] POS_BPP_LO  = 6'd28;
	localparam logic [5:0] POS_BPP_HI  = 6'd29;
	localparam logic [5:0] POS_HDR_END = 6'd53;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic signed [31:0] image_width;
		logic signed [31:0] image_height;
		logic               last;
	} result_t;

endpackage

// ===== rtl/bmp24_parser.sv =====
// Header parser and pixel assembler: parse state and per-byte result logic.
// Depends on bmp24_pkg.
module bmp24_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              start_req,
	output logic              res_valid,
	output bmp24_pkg::result_t res
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;

	logic [1:0]  phase_q, phase_n, cur_phase;
	logic [5:0]  pos_q, pos_n, cur_pos;
	logic [7:0]  sig_lo_q, sig_lo_n;
	logic [7:0]  bpp_lo_q, bpp_lo_n;
	logic [31:0] width_q, width_n;
	logic [31:0] height_q, height_n;
	logic [31:0] col_q, col_n, col_inc;
	logic [31:0] rows_q, rows_n;
	logic [1:0]  bip_q, bip_n;
	logic [1:0]  pad_q, pad_n;
	logic [7:0]  blue_q, blue_n;
	logic [7:0]  green_q, green_n;
	logic        empty_img;

	assign cur_phase = start_req ? PH_HEADER : phase_q;
	assign cur_pos   = start_req ? 6'd0 : pos_q;
	assign col_inc   = col_q + 32'd1;
	assign empty_img = (width_q == 32'd0) || width_q[31] || (height_q == 32'd0) || height_q[31];

	always_comb begin
		phase_n   = cur_phase;
		pos_n     = cur_pos;
		sig_lo_n  = sig_lo_q;
		bpp_lo_n  = bpp_lo_q;
		width_n   = width_q;
		height_n  = height_q;
		col_n     = col_q;
		rows_n    = rows_q;
		bip_n     = bip_q;
		pad_n     = pad_q;
		blue_n    = blue_q;
		green_n   = green_q;
		res_valid = 1'b0;
		res       = '0;
		case (cur_phase)
			PH_HEADER: begin
				pos_n = cur_pos + 6'd1;
				case (cur_pos)
					bmp24_pkg::POS_SIG_LO: sig_lo_n = data_byte;
					bmp24_pkg::POS_W0:     width_n[7:0]    = data_byte;
					bmp24_pkg::POS_W1:     width_n[15:8]   = data_byte;
					bmp24_pkg::POS_W2:     width_n[23:16]  = data_byte;
					bmp24_pkg::POS_W3:     width_n[31:24]  = data_byte;
					bmp24_pkg::POS_H0:     height_n[7:0]   = data_byte;
					bmp24_pkg::POS_H1:     height_n[15:8]  = data_byte;
					bmp24_pkg::POS_H2:     height_n[23:16] = data_byte;
					bmp24_pkg::POS_H3:     height_n[31:24] = data_byte;
					bmp24_pkg::POS_BPP_LO: bpp_lo_n = data_byte;
					default: ;
				endcase
				if (cur_pos == bmp24_pkg::POS_SIG_HI && {data_byte, sig_lo_q} != bmp24_pkg::BMP_MAGIC) begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = bmp24_pkg::KIND_ERR_SIG;
				end else if (cur_pos == bmp24_pkg::POS_BPP_HI &&
						{data_byte, bpp_lo_q} != bmp24_pkg::BMP_BITS) begin
					phase_n   = PH_IDLE;
					res_valid = 1'b1;
					res.kind  = bmp24_pkg::KIND_ERR_BPP;
				end else if (cur_pos == bmp24_pkg::POS_HDR_END) begin
					res_valid        = 1'b1;
					res.kind         = bmp24_pkg::KIND_HEADER;
					res.image_width  = width_q;
					res.image_height = height_q;
					if (empty_img) begin
						phase_n  = PH_IDLE;
						res.last = 1'b1;
					end else begin
						phase_n = PH_PIXELS;
						rows_n  = height_q;
						col_n   = 32'd0;
						bip_n   = 2'd0;
						pad_n   = 2'd0;
					end
				end
			end
			PH_PIXELS: begin
				if (pad_q != 2'd0) begin
					pad_n = pad_q - 2'd1;
				end else if (bip_q == 2'd0) begin
					blue_n = data_byte;
					bip_n  = 2'd1;
				end else if (bip_q == 2'd1) begin
					green_n = data_byte;
					bip_n   = 2'd2;
				end else begin
					bip_n     = 2'd0;
					col_n     = col_inc;
					res_valid = 1'b1;
					res.kind  = bmp24_pkg::KIND_PIXEL;
					res.red   = data_byte;
					res.green = green_q;
					res.blue  = blue_q;
					if (col_inc == width_q) begin
						col_n  = 32'd0;
						rows_n = rows_q - 32'd1;
						pad_n  = width_q[1:0];
						if (rows_q == 32'd1) begin
							phase_n  = PH_IDLE;
							pad_n    = 2'd0;
							res.last = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= 6'd0;
			col_q   <= 32'd0;
			rows_q  <= 32'd0;
			bip_q   <= 2'd0;
			pad_q   <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			col_q   <= col_n;
			rows_q  <= rows_n;
			bip_q   <= bip_n;
			pad_q   <= pad_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sig_lo_q <= sig_lo_n;
			bpp_lo_q <= bpp_lo_n;
			width_q  <= width_n;
			height_q <= height_n;
			blue_q   <= blue_n;
			green_q  <= green_n;
		end
	end

endmodule

// ===== rtl/bmp24_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
// Depends on bmp24_pkg.
module bmp24_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic               res_valid,
	input  bmp24_pkg::result_t res,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               slot_free,
	output bmp24_pkg::result_t res_q
);

	logic valid_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && load_en && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/bmp24_stream_to_rgba_core.sv =====
// 24-bit bitmap byte-stream decoder: one file byte per transfer in, header/error/pixel results out.
// Accepts one byte every cycle while in_ready is high; a result appears in the output register
// the cycle after its byte, and in_ready drops only while that register holds an untaken result.
// Depends on bmp24_pkg, bmp24_parser, bmp24_out_reg.
module bmp24_stream_to_rgba_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic signed [31:0] image_width,
	output logic signed [31:0] image_height,
	output logic               last
);

	logic               accept;
	logic               res_valid;
	bmp24_pkg::result_t res;
	bmp24_pkg::result_t res_q;

	assign accept = in_valid && in_ready;

	bmp24_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.start_req (start_req),
		.res_valid (res_valid),
		.res       (res)
	);

	bmp24_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (accept),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.slot_free (in_ready),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign red          = res_q.red;
	assign green        = res_q.green;
	assign blue         = res_q.blue;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;
	assign last         = res_q.last;

endmodule

// ===== rtl/bmp24_chk.sv =====
// Port-level checker for the bitmap decoder, bound to the top level.
// Depends on bmp24_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmp24_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        kind,
	input logic [7:0]        red,
	input logic [7:0]        green,
	input logic [7:0]        blue,
	input logic signed [31:0] image_width,
	input logic signed [31:0] image_height,
	input logic              last
);

	logic is_err;
	logic img_pos;
	logic out_stall;
	logic is_pixel;
	logic is_hdr;
	logic dims_zero;
	logic rgb_zero;

	assign is_err  = (kind == bmp24_pkg::KIND_ERR_SIG) || (kind == bmp24_pkg::KIND_ERR_BPP);
	assign img_pos = !image_width[31] && (image_width != 32'sd0) &&
		!image_height[31] && (image_height != 32'sd0);
	assign out_stall = out_valid && !out_ready;
	assign is_pixel  = out_valid && (kind == bmp24_pkg::KIND_PIXEL);
	assign is_hdr    = out_valid && (kind == bmp24_pkg::KIND_HEADER);
	assign dims_zero = (image_width == 32'sd0) && (image_height == 32'sd0);
	assign rgb_zero  = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);

	`BMP24_AST_NEXT(a_out_hold, out_stall, out_valid && $stable(kind) && $stable(last))
	`BMP24_AST_IMPLY(a_ready_when_empty, !out_valid, in_ready)
	`BMP24_AST_IMPLY(a_pixel_no_dims, is_pixel, dims_zero)
	`BMP24_AST_IMPLY(a_err_clean, out_valid && is_err, !last && rgb_zero)
	`BMP24_AST_IMPLY(a_hdr_last, is_hdr, last == !img_pos)

endmodule

bind bmp24_stream_to_rgba_core bmp24_chk u_bmp24_chk (.*);
